>>> hw/rtl/assert_macros.svh
// Assertion macros used by the region table controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTWL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTWL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RTWL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/rtwl_pkg.sv
// Types and constants shared by the region table modules.
package rtwl_pkg;

    typedef enum logic [3:0] {
        CMD_ADD        = 4'd0,
        CMD_DELETE     = 4'd1,
        CMD_GET_SLOT   = 4'd2,
        CMD_CLEAR      = 4'd3,
        CMD_PURGE      = 4'd4,
        CMD_COUNT      = 4'd5,
        CMD_FIND_BTN   = 4'd6,
        CMD_FIND_IP    = 4'd7,
        CMD_SET_STATE  = 4'd8,
        CMD_GET_STATE  = 4'd9,
        CMD_TICK       = 4'd10,
        CMD_EXPIRE     = 4'd11
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EVAL,
        S_DIV,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [7:0]  region;
        logic [7:0]  button;
    } slot_entry_t;

    typedef struct packed {
        logic [2:0]  state;
        logic        fresh;
        logic [15:0] counter;
    } btn_entry_t;

    typedef struct packed {
        logic load;
        logic decode_exec;
        logic eval_exec;
        logic idx_inc;
        logic phase_next;
        logic div_step;
        logic div_wb;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic slot_in;
        logic btn_in;
        logic last;
        logic hit;
        logic need_div;
        logic div_done;
        logic link_phase;
    } stat_t;

    localparam logic [31:0] BLANK_IP   = 32'hFFFF_FFFF;
    localparam logic [7:0]  BLANK_BYTE = 8'hA5;
    localparam logic [2:0]  ST_ABSENT  = 3'd0;
    localparam logic [2:0]  ST_MAX     = 3'd4;

    localparam logic [15:0] PERIOD_RESET = 16'd400;
    localparam logic [7:0]  LIMIT_RESET  = 8'd8;

    localparam logic [1:0] CFG_REFRESH_PERIOD = 2'd0;
    localparam logic [1:0] CFG_REGION_LIMIT   = 2'd1;

    localparam logic [4:0] DIV_STEPS = 5'd16;
    localparam logic [4:0] COUNT_MAX = 5'd31;

    localparam slot_entry_t SLOT_BLANK = '{ip: BLANK_IP, region: BLANK_BYTE, button: BLANK_BYTE};
    localparam btn_entry_t  BTN_RESET  = '{state: ST_ABSENT, fresh: 1'b1, counter: 16'd0};

endpackage

>>> hw/rtl/rtwl_controller.sv
// Command sequencer for the region table.
`include "assert_macros.svh"

module rtwl_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    input  rtwl_pkg::stat_t stat,
    output rtwl_pkg::ctrl_t ctrl
);

    rtwl_pkg::fsm_t state_reg;
    rtwl_pkg::fsm_t state_next;

    logic decode_sweeps;
    logic eval_stop;
    logic eval_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtwl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        decode_sweeps = 1'b0;
        eval_stop     = 1'b1;
        eval_div      = 1'b0;
        unique case (stat.cmd)
            rtwl_pkg::CMD_DELETE, rtwl_pkg::CMD_GET_SLOT:
            begin
                decode_sweeps = stat.slot_in;
            end
            rtwl_pkg::CMD_GET_STATE:
            begin
                decode_sweeps = stat.btn_in;
            end
            rtwl_pkg::CMD_CLEAR, rtwl_pkg::CMD_COUNT:
            begin
                decode_sweeps = 1'b1;
                eval_stop     = stat.last;
            end
            rtwl_pkg::CMD_FIND_BTN, rtwl_pkg::CMD_FIND_IP:
            begin
                decode_sweeps = 1'b1;
                eval_stop     = stat.hit || stat.last;
            end
            rtwl_pkg::CMD_TICK:
            begin
                decode_sweeps = 1'b1;
                eval_div      = stat.need_div;
                eval_stop     = !stat.need_div && stat.last;
            end
            rtwl_pkg::CMD_EXPIRE:
            begin
                decode_sweeps = 1'b1;
                eval_stop     = stat.last && stat.link_phase;
            end
            default:
            begin
                decode_sweeps = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtwl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = rtwl_pkg::S_DECODE;
                end
            end
            rtwl_pkg::S_DECODE:
            begin
                state_next = decode_sweeps ? rtwl_pkg::S_READ : rtwl_pkg::S_DONE;
            end
            rtwl_pkg::S_READ:
            begin
                state_next = rtwl_pkg::S_EVAL;
            end
            rtwl_pkg::S_EVAL:
            begin
                if (eval_stop)
                begin
                    state_next = rtwl_pkg::S_DONE;
                end
                else if (eval_div)
                begin
                    state_next = rtwl_pkg::S_DIV;
                end
                else
                begin
                    state_next = rtwl_pkg::S_READ;
                end
            end
            rtwl_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.last ? rtwl_pkg::S_DONE : rtwl_pkg::S_READ;
                end
            end
            rtwl_pkg::S_DONE:
            begin
                state_next = rtwl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rtwl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl             = '0;
        busy             = (state_reg != rtwl_pkg::S_IDLE);
        done             = (state_reg == rtwl_pkg::S_DONE);
        ctrl.load        = (state_reg == rtwl_pkg::S_IDLE) && start;
        ctrl.decode_exec = (state_reg == rtwl_pkg::S_DECODE) && !decode_sweeps;
        ctrl.eval_exec   = (state_reg == rtwl_pkg::S_EVAL);
        if (state_reg == rtwl_pkg::S_EVAL && !eval_stop && !eval_div)
        begin
            if (stat.last)
            begin
                ctrl.phase_next = 1'b1;
            end
            else
            begin
                ctrl.idx_inc = 1'b1;
            end
        end
        if (state_reg == rtwl_pkg::S_DIV)
        begin
            ctrl.div_step = !stat.div_done;
            ctrl.div_wb   = stat.div_done;
            ctrl.idx_inc  = stat.div_done && !stat.last;
        end
    end

    `RTWL_ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `RTWL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
    `RTWL_ASSERT_IMPL(a_div_step, clk, rst_n, ctrl.div_step, !stat.div_done)
    `RTWL_ASSERT_IMPL(a_phase_expire, clk, rst_n, ctrl.phase_next, !stat.link_phase)

endmodule

>>> hw/rtl/rtwl_datapath.sv
// Slot table, button state store, remainder unit and result registers.
module rtwl_datapath #(
    parameter int SLOTS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rtwl_pkg::ctrl_t ctrl,
    output rtwl_pkg::stat_t stat,
    input  logic [3:0]      cmd,
    input  logic [7:0]      slot,
    input  logic [31:0]     ip_address,
    input  logic [7:0]      region_number,
    input  logic [7:0]      button,
    input  logic [2:0]      new_state,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    output logic            error,
    output logic            found,
    output logic [3:0]      found_slot,
    output logic [31:0]     entry_ip,
    output logic [7:0]      entry_region,
    output logic [7:0]      entry_button,
    output logic [2:0]      state_out,
    output logic [4:0]      entry_count
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [7:0] SLOTS_B = 8'(SLOTS);

    rtwl_pkg::cmd_t        cmd_reg;
    logic [7:0]            slot_reg;
    logic [31:0]           ip_reg;
    logic [7:0]            region_reg;
    logic [7:0]            button_reg;
    logic [2:0]            nstate_reg;
    logic [AW-1:0]         idx_reg;
    logic                  link_phase_reg;
    logic [SLOTS-1:0]      linked_reg;
    logic [CW-1:0]         cnt_reg;
    logic [15:0]           period_reg;
    logic [7:0]            limit_reg;

    rtwl_pkg::slot_entry_t slot_mem_reg [SLOTS];
    rtwl_pkg::btn_entry_t  btn_mem_reg [SLOTS];
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [SLOTS-1:0]      btn_valid_reg;
    rtwl_pkg::slot_entry_t slot_rd_reg;
    rtwl_pkg::btn_entry_t  btn_rd_reg;
    logic                  slot_rdv_reg;
    logic                  btn_rdv_reg;

    logic [4:0]            div_cnt_reg;
    logic [15:0]           div_num_reg;
    logic [15:0]           div_rem_reg;

    logic                  error_reg;
    logic                  found_reg;
    logic [3:0]            found_slot_reg;
    rtwl_pkg::slot_entry_t entry_reg;
    logic [2:0]            state_out_reg;
    logic [4:0]            entry_count_reg;

    rtwl_pkg::slot_entry_t slot_cur;
    rtwl_pkg::btn_entry_t  btn_cur;
    logic                  slot_blank;
    logic                  slot_btn_in;
    logic                  match_btn;
    logic                  match_ip;
    logic                  need_div;
    logic [15:0]           cnt_inc;
    logic [15:0]           period_eff;
    logic [16:0]           rem_shift;
    logic [15:0]           rem_step;
    logic                  slot_in;
    logic                  btn_in;
    logic                  count_hit;
    logic [CW-1:0]         cnt_sum;

    logic                  slot_we;
    logic [AW-1:0]         slot_waddr;
    rtwl_pkg::slot_entry_t slot_wdata;
    logic                  slot_clr;
    logic                  btn_we;
    logic [AW-1:0]         btn_waddr;
    rtwl_pkg::btn_entry_t  btn_wdata;
    logic                  purge;
    logic                  err_set;
    logic                  emit;
    logic                  state_load;
    logic                  count_load;
    logic                  link_set;
    logic                  div_start;

    assign slot_cur    = slot_rdv_reg ? slot_rd_reg : rtwl_pkg::SLOT_BLANK;
    assign btn_cur     = btn_rdv_reg ? btn_rd_reg : rtwl_pkg::BTN_RESET;
    assign slot_blank  = (slot_cur == rtwl_pkg::SLOT_BLANK);
    assign slot_btn_in = (slot_cur.button < SLOTS_B);
    assign slot_in     = (slot_reg < SLOTS_B);
    assign btn_in      = (button_reg < SLOTS_B);
    assign match_btn   = !slot_blank && (slot_cur.button == button_reg);
    assign match_ip    = !slot_blank && (slot_cur.ip == ip_reg) && (slot_cur.region == region_reg);
    assign need_div    = btn_cur.fresh && (btn_cur.state != rtwl_pkg::ST_ABSENT);
    assign cnt_inc     = btn_cur.counter + 16'd1;
    assign period_eff  = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign rem_shift   = {div_rem_reg, div_num_reg[15]};
    assign rem_step    = (rem_shift >= {1'b0, period_eff}) ?
                         16'(rem_shift - {1'b0, period_eff}) : rem_shift[15:0];
    assign count_hit   = (slot_cur.ip != rtwl_pkg::BLANK_IP)
                         && (slot_cur.region != rtwl_pkg::BLANK_BYTE)
                         && (slot_cur.region < limit_reg)
                         && (slot_cur.button != rtwl_pkg::BLANK_BYTE)
                         && slot_btn_in;
    assign cnt_sum     = cnt_reg + CW'(count_hit);

    always_comb
    begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.slot_in    = slot_in;
        stat.btn_in     = btn_in;
        stat.last       = (idx_reg == AW'(SLOTS - 1));
        stat.hit        = (cmd_reg == rtwl_pkg::CMD_FIND_BTN && match_btn)
                          || (cmd_reg == rtwl_pkg::CMD_FIND_IP && match_ip);
        stat.need_div   = need_div;
        stat.div_done   = (div_cnt_reg == 5'd0);
        stat.link_phase = link_phase_reg;
    end

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = rtwl_pkg::SLOT_BLANK;
        slot_clr   = 1'b0;
        btn_we     = 1'b0;
        btn_waddr  = idx_reg;
        btn_wdata  = rtwl_pkg::BTN_RESET;
        purge      = 1'b0;
        err_set    = 1'b0;
        emit       = 1'b0;
        state_load = 1'b0;
        count_load = 1'b0;
        link_set   = 1'b0;
        div_start  = 1'b0;
        if (ctrl.decode_exec)
        begin
            unique case (cmd_reg)
                rtwl_pkg::CMD_ADD:
                begin
                    if (slot_in && region_reg < limit_reg && btn_in)
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = slot_reg[AW-1:0];
                        slot_wdata = '{ip: ip_reg, region: region_reg, button: button_reg};
                    end
                    else
                    begin
                        err_set = 1'b1;
                    end
                end
                rtwl_pkg::CMD_DELETE, rtwl_pkg::CMD_GET_SLOT, rtwl_pkg::CMD_GET_STATE:
                begin
                    err_set = 1'b1;
                end
                rtwl_pkg::CMD_SET_STATE:
                begin
                    if (!btn_in)
                    begin
                        err_set = 1'b1;
                    end
                    else if (nstate_reg <= rtwl_pkg::ST_MAX)
                    begin
                        btn_we    = 1'b1;
                        btn_wdata = '{state: nstate_reg, fresh: 1'b1, counter: 16'd0};
                    end
                end
                rtwl_pkg::CMD_PURGE:
                begin
                    purge = 1'b1;
                end
                default:
                begin
                    purge = 1'b0;
                end
            endcase
        end
        if (ctrl.eval_exec)
        begin
            unique case (cmd_reg)
                rtwl_pkg::CMD_DELETE, rtwl_pkg::CMD_CLEAR:
                begin
                    if (cmd_reg == rtwl_pkg::CMD_DELETE && slot_blank)
                    begin
                        err_set = 1'b1;
                    end
                    else if (!slot_blank
                             && (cmd_reg == rtwl_pkg::CMD_DELETE || slot_cur.ip != 32'd0))
                    begin
                        slot_clr  = 1'b1;
                        btn_we    = slot_btn_in;
                        btn_waddr = slot_cur.button[AW-1:0];
                    end
                end
                rtwl_pkg::CMD_GET_SLOT:
                begin
                    emit = !slot_blank;
                end
                rtwl_pkg::CMD_GET_STATE:
                begin
                    state_load = 1'b1;
                end
                rtwl_pkg::CMD_COUNT:
                begin
                    count_load = 1'b1;
                end
                rtwl_pkg::CMD_FIND_BTN:
                begin
                    emit = match_btn;
                end
                rtwl_pkg::CMD_FIND_IP:
                begin
                    emit = match_ip;
                end
                rtwl_pkg::CMD_TICK:
                begin
                    if (need_div)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        btn_we    = 1'b1;
                        btn_wdata = '{state: btn_cur.state, fresh: btn_cur.fresh,
                                      counter: cnt_inc};
                    end
                end
                rtwl_pkg::CMD_EXPIRE:
                begin
                    if (!link_phase_reg)
                    begin
                        link_set = !slot_blank && slot_btn_in;
                    end
                    else if (!btn_cur.fresh && btn_cur.state != rtwl_pkg::ST_ABSENT
                             && linked_reg[idx_reg])
                    begin
                        btn_we    = 1'b1;
                        btn_wdata = '{state: rtwl_pkg::ST_ABSENT, fresh: btn_cur.fresh,
                                      counter: btn_cur.counter};
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        if (ctrl.div_wb)
        begin
            btn_we    = 1'b1;
            btn_wdata = '{state: btn_cur.state, fresh: (div_rem_reg != 16'd0),
                          counter: cnt_inc};
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem_reg[slot_waddr] <= slot_wdata;
        end
        if (btn_we)
        begin
            btn_mem_reg[btn_waddr] <= btn_wdata;
        end
        slot_rd_reg <= slot_mem_reg[idx_reg];
        btn_rd_reg  <= btn_mem_reg[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            btn_valid_reg  <= '0;
            slot_rdv_reg   <= 1'b0;
            btn_rdv_reg    <= 1'b0;
        end
        else
        begin
            slot_rdv_reg <= slot_valid_reg[idx_reg];
            btn_rdv_reg  <= btn_valid_reg[idx_reg];
            if (purge)
            begin
                slot_valid_reg <= '0;
                btn_valid_reg  <= '0;
            end
            else
            begin
                if (slot_we)
                begin
                    slot_valid_reg[slot_waddr] <= 1'b1;
                end
                if (slot_clr)
                begin
                    slot_valid_reg[idx_reg] <= 1'b0;
                end
                if (btn_we)
                begin
                    btn_valid_reg[btn_waddr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= rtwl_pkg::PERIOD_RESET;
            limit_reg      <= rtwl_pkg::LIMIT_RESET;
            cmd_reg        <= rtwl_pkg::CMD_ADD;
            idx_reg        <= '0;
            link_phase_reg <= 1'b0;
            div_cnt_reg    <= 5'd0;
        end
        else
        begin
            if (cfg_valid && cfg_index == rtwl_pkg::CFG_REFRESH_PERIOD)
            begin
                period_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == rtwl_pkg::CFG_REGION_LIMIT)
            begin
                limit_reg <= cfg_data[7:0];
            end
            if (ctrl.load)
            begin
                cmd_reg        <= rtwl_pkg::cmd_t'(cmd);
                link_phase_reg <= 1'b0;
                if (cmd == rtwl_pkg::CMD_SET_STATE || cmd == rtwl_pkg::CMD_GET_STATE)
                begin
                    idx_reg <= button[AW-1:0];
                end
                else if (cmd == rtwl_pkg::CMD_DELETE || cmd == rtwl_pkg::CMD_GET_SLOT)
                begin
                    idx_reg <= slot[AW-1:0];
                end
                else
                begin
                    idx_reg <= '0;
                end
            end
            else if (ctrl.phase_next)
            begin
                idx_reg        <= '0;
                link_phase_reg <= 1'b1;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (div_start)
            begin
                div_cnt_reg <= rtwl_pkg::DIV_STEPS;
            end
            else if (ctrl.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            slot_reg        <= slot;
            ip_reg          <= ip_address;
            region_reg      <= region_number;
            button_reg      <= button;
            nstate_reg      <= new_state;
            linked_reg      <= '0;
            cnt_reg         <= '0;
            error_reg       <= 1'b0;
            found_reg       <= 1'b0;
            found_slot_reg  <= 4'd0;
            entry_reg       <= '0;
            state_out_reg   <= rtwl_pkg::ST_ABSENT;
            entry_count_reg <= 5'd0;
        end
        else
        begin
            if (err_set)
            begin
                error_reg <= 1'b1;
            end
            if (emit)
            begin
                found_reg      <= 1'b1;
                found_slot_reg <= 4'(idx_reg);
                entry_reg      <= slot_cur;
            end
            if (state_load)
            begin
                state_out_reg <= btn_cur.state;
            end
            if (count_load)
            begin
                cnt_reg         <= cnt_sum;
                entry_count_reg <= (cnt_sum > CW'(rtwl_pkg::COUNT_MAX)) && (CW > 5) ?
                                   rtwl_pkg::COUNT_MAX : 5'(cnt_sum);
            end
            if (link_set)
            begin
                linked_reg[slot_cur.button[AW-1:0]] <= 1'b1;
            end
        end
        if (div_start)
        begin
            div_num_reg <= cnt_inc;
            div_rem_reg <= 16'd0;
        end
        else if (ctrl.div_step)
        begin
            div_num_reg <= {div_num_reg[14:0], 1'b0};
            div_rem_reg <= rem_step;
        end
    end

    assign cfg_ready    = 1'b1;
    assign error        = error_reg;
    assign found        = found_reg;
    assign found_slot   = found_slot_reg;
    assign entry_ip     = entry_reg.ip;
    assign entry_region = entry_reg.region;
    assign entry_button = entry_reg.button;
    assign state_out    = state_out_reg;
    assign entry_count  = entry_count_reg;

endmodule

>>> hw/rtl/region_table_with_liveness.sv
// Top level of the region table with per-button liveness tracking.
//
// A command item is taken at a rising edge with start high and busy low; busy
// stays high until the result has been shown. Each command gives one result,
// shown for exactly one cycle with done high; the receiver cannot stall it.
// A command that reads no entry is executed in decode and goes straight to
// done. Get slot, delete and get state read one entry when their index is in
// range. Sweeping commands visit each slot through a read and an evaluate
// state; clear and count visit every slot, a lookup ends at its first match,
// and expire makes a link pass over slots, then a button pass.
// For each fresh, non-absent button, tick also runs the bit-serial remainder
// unit for the refresh period check.
// The next command can be accepted in the cycle after done.
// Configuration writes on the cfg channel are always ready and must arrive
// only while busy is low. Reset puts every slot blank, every button absent and
// fresh with a zero counter, and restores the register defaults; valid bits
// make this immediate, with no clearing pass.
module region_table_with_liveness #(
    parameter int SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [7:0]  slot,
    input  logic [31:0] ip_address,
    input  logic [7:0]  region_number,
    input  logic [7:0]  button,
    input  logic [2:0]  new_state,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic        error,
    output logic        found,
    output logic [3:0]  found_slot,
    output logic [31:0] entry_ip,
    output logic [7:0]  entry_region,
    output logic [7:0]  entry_button,
    output logic [2:0]  state_out,
    output logic [4:0]  entry_count
);

    rtwl_pkg::ctrl_t ctrl;
    rtwl_pkg::stat_t stat;

    rtwl_controller u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rtwl_datapath #(
        .SLOTS (SLOTS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cmd           (cmd),
        .slot          (slot),
        .ip_address    (ip_address),
        .region_number (region_number),
        .button        (button),
        .new_state     (new_state),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error         (error),
        .found         (found),
        .found_slot    (found_slot),
        .entry_ip      (entry_ip),
        .entry_region  (entry_region),
        .entry_button  (entry_button),
        .state_out     (state_out),
        .entry_count   (entry_count)
    );

endmodule

>>> bench/region_table_with_liveness_test.sv
// Self-checking testbench for the region table with button liveness tracking.
module region_table_with_liveness_test;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  slot;
        logic [31:0] ip;
        logic [7:0]  region;
        logic [7:0]  button;
        logic [2:0]  nstate;
    } item_t;

    typedef struct packed {
        logic        error;
        logic        found;
        logic [3:0]  found_slot;
        logic [31:0] entry_ip;
        logic [7:0]  entry_region;
        logic [7:0]  entry_button;
        logic [2:0]  state_out;
        logic [4:0]  entry_count;
    } reply_t;

    typedef struct {
        item_t  it;
        logic   has_reply;
        reply_t reply;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  cmd;
    logic [7:0]  slot;
    logic [31:0] ip_address;
    logic [7:0]  region_number;
    logic [7:0]  button;
    logic [2:0]  new_state;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic        error;
    logic        found;
    logic [3:0]  found_slot;
    logic [31:0] entry_ip;
    logic [7:0]  entry_region;
    logic [7:0]  entry_button;
    logic [2:0]  state_out;
    logic [4:0]  entry_count;

    logic [31:0] m_ip     [NSLOT];
    logic [7:0]  m_region [NSLOT];
    logic [7:0]  m_button [NSLOT];
    logic [2:0]  m_state  [NSLOT];
    logic        m_fresh  [NSLOT];
    logic [15:0] m_count  [NSLOT];
    logic [15:0] m_period;
    logic [7:0]  m_limit;

    reply_t pending_replies[$];
    int     fail_count;
    row_t   script[$];

    region_table_with_liveness u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .slot(slot),
        .ip_address(ip_address), .region_number(region_number), .button(button),
        .new_state(new_state), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .error(error),
        .found(found), .found_slot(found_slot), .entry_ip(entry_ip),
        .entry_region(entry_region), .entry_button(entry_button),
        .state_out(state_out), .entry_count(entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic slot_blank(int i);
        return m_ip[i] == rtwl_pkg::BLANK_IP && m_region[i] == rtwl_pkg::BLANK_BYTE
               && m_button[i] == rtwl_pkg::BLANK_BYTE;
    endfunction

    function automatic void purge_table();
        for (int i = 0; i < NSLOT; i++)
        begin
            m_ip[i] = rtwl_pkg::BLANK_IP;
            m_region[i] = rtwl_pkg::BLANK_BYTE;
            m_button[i] = rtwl_pkg::BLANK_BYTE;
            m_state[i] = rtwl_pkg::ST_ABSENT;
            m_fresh[i] = 1'b1;
            m_count[i] = '0;
        end
    endfunction

    function automatic void refresh_button(logic [7:0] b, logic [2:0] st);
        if (b < NSLOT && st <= rtwl_pkg::ST_MAX)
        begin
            m_state[b[3:0]] = st;
            m_fresh[b[3:0]] = 1'b1;
            m_count[b[3:0]] = '0;
        end
    endfunction

    function automatic void blank_entry(int i);
        refresh_button(m_button[i], rtwl_pkg::ST_ABSENT);
        m_ip[i] = rtwl_pkg::BLANK_IP;
        m_region[i] = rtwl_pkg::BLANK_BYTE;
        m_button[i] = rtwl_pkg::BLANK_BYTE;
    endfunction

    function automatic void show_entry(ref reply_t r, input int i);
        r.found = 1'b1;
        r.found_slot = i[3:0];
        r.entry_ip = m_ip[i];
        r.entry_region = m_region[i];
        r.entry_button = m_button[i];
    endfunction

    function automatic reply_t table_step(item_t it);
        reply_t r;
        int n;
        logic [15:0] per;
        logic hit;
        r = '0;
        per = (m_period == 0) ? 16'd1 : m_period;
        case (it.cmd)
            rtwl_pkg::CMD_ADD:
                if (it.slot < NSLOT && it.region < m_limit && it.button < NSLOT)
                begin
                    m_ip[it.slot[3:0]] = it.ip;
                    m_region[it.slot[3:0]] = it.region;
                    m_button[it.slot[3:0]] = it.button;
                end
                else
                    r.error = 1'b1;
            rtwl_pkg::CMD_DELETE:
                if (it.slot < NSLOT && !slot_blank(it.slot))
                    blank_entry(it.slot);
                else
                    r.error = 1'b1;
            rtwl_pkg::CMD_GET_SLOT:
                if (it.slot >= NSLOT)
                    r.error = 1'b1;
                else if (!slot_blank(it.slot))
                    show_entry(r, it.slot);
            rtwl_pkg::CMD_CLEAR:
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_blank(i) && m_ip[i] != 0)
                        blank_entry(i);
            rtwl_pkg::CMD_PURGE:
                purge_table();
            rtwl_pkg::CMD_COUNT:
            begin
                n = 0;
                for (int i = 0; i < NSLOT; i++)
                    if (m_ip[i] != rtwl_pkg::BLANK_IP && m_region[i] != rtwl_pkg::BLANK_BYTE
                        && m_region[i] < m_limit && m_button[i] != rtwl_pkg::BLANK_BYTE
                        && m_button[i] < NSLOT)
                        n++;
                r.entry_count = (n > 31) ? 5'd31 : n[4:0];
            end
            rtwl_pkg::CMD_FIND_BTN:
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_blank(i) && m_button[i] == it.button)
                    begin
                        show_entry(r, i);
                        break;
                    end
            rtwl_pkg::CMD_FIND_IP:
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_blank(i) && m_ip[i] == it.ip && m_region[i] == it.region)
                    begin
                        show_entry(r, i);
                        break;
                    end
            rtwl_pkg::CMD_SET_STATE:
                if (it.button >= NSLOT)
                    r.error = 1'b1;
                else
                    refresh_button(it.button, it.nstate);
            rtwl_pkg::CMD_GET_STATE:
                if (it.button >= NSLOT)
                    r.error = 1'b1;
                else
                    r.state_out = m_state[it.button[3:0]];
            rtwl_pkg::CMD_TICK:
                for (int i = 0; i < NSLOT; i++)
                begin
                    m_count[i] = m_count[i] + 16'd1;
                    if (m_count[i] % per == 0 && m_state[i] != rtwl_pkg::ST_ABSENT)
                        m_fresh[i] = 1'b0;
                end
            rtwl_pkg::CMD_EXPIRE:
                for (int i = 0; i < NSLOT; i++)
                    if (!m_fresh[i] && m_state[i] != rtwl_pkg::ST_ABSENT)
                    begin
                        hit = 1'b0;
                        for (int k = 0; k < NSLOT; k++)
                            if (!slot_blank(k) && m_button[k] == i)
                                hit = 1'b1;
                        if (hit)
                            m_state[i] = rtwl_pkg::ST_ABSENT;
                    end
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_replies.pop_front();
                if (error !== e.error)
                begin
                    $error("error exp %0h got %0h", e.error, error);
                    fail_count++;
                end
                if (found !== e.found)
                begin
                    $error("found exp %0h got %0h", e.found, found);
                    fail_count++;
                end
                if (found_slot !== e.found_slot)
                begin
                    $error("found_slot exp %0h got %0h", e.found_slot, found_slot);
                    fail_count++;
                end
                if (entry_ip !== e.entry_ip)
                begin
                    $error("entry_ip exp %0h got %0h", e.entry_ip, entry_ip);
                    fail_count++;
                end
                if (entry_region !== e.entry_region)
                begin
                    $error("entry_region exp %0h got %0h", e.entry_region, entry_region);
                    fail_count++;
                end
                if (entry_button !== e.entry_button)
                begin
                    $error("entry_button exp %0h got %0h", e.entry_button, entry_button);
                    fail_count++;
                end
                if (state_out !== e.state_out)
                begin
                    $error("state_out exp %0h got %0h", e.state_out, state_out);
                    fail_count++;
                end
                if (entry_count !== e.entry_count)
                begin
                    $error("entry_count exp %0h got %0h", e.entry_count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Start stays high after acceptance; the caller drops it before any idle time.
    task automatic send_item(item_t it, logic has_reply, reply_t given);
        reply_t p;
        start <= 1'b1;
        cmd <= it.cmd;
        slot <= it.slot;
        ip_address <= it.ip;
        region_number <= it.region;
        button <= it.button;
        new_state <= it.nstate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = table_step(it);
        if (has_reply && p !== given)
        begin
            $error("table row disagrees with prediction for cmd %0d", it.cmd);
            fail_count++;
        end
        pending_replies.push_back(p);
    endtask

    task automatic wait_idle();
        int guard;
        start <= 1'b0;
        guard = 0;
        while ((pending_replies.size() != 0 || busy) && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == rtwl_pkg::CFG_REFRESH_PERIOD)
            m_period = val;
        else
            m_limit = val[7:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic item_t mk(logic [3:0] c, logic [7:0] s, logic [31:0] ip,
                                 logic [7:0] rg, logic [7:0] b, logic [2:0] ns);
        item_t it;
        it.cmd = c;
        it.slot = s;
        it.ip = ip;
        it.region = rg;
        it.button = b;
        it.nstate = ns;
        return it;
    endfunction

    function automatic void add_row(item_t it, logic has, reply_t r);
        row_t rw;
        rw.it = it;
        rw.has_reply = has;
        rw.reply = r;
        script.push_back(rw);
    endfunction

    function automatic item_t random_item();
        item_t it;
        logic [63:0] raw;
        int pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 20)
            it.cmd = rtwl_pkg::CMD_ADD;
        else if (pick < 30)
            it.cmd = rtwl_pkg::CMD_TICK;
        else if (pick < 95)
            it.cmd = 4'($urandom_range(0, 11));
        else
            it.cmd = 4'($urandom_range(12, 15));
        if ($urandom_range(0, 9) < 8)
        begin
            it.slot = 8'($urandom_range(0, NSLOT - 1));
            it.button = 8'($urandom_range(0, NSLOT - 1));
            it.region = 8'($urandom_range(0, m_limit));
        end
        if ($urandom_range(0, 3) == 0)
            it.ip = m_ip[$urandom_range(0, NSLOT - 1)];
        if ($urandom_range(0, 7) == 0)
            it.ip = 0;
        if ($urandom_range(0, 3) != 0 && m_region[it.slot[3:0]] != rtwl_pkg::BLANK_BYTE)
            it.region = m_region[it.slot[3:0]];
        if ($urandom_range(0, 3) == 0)
            it.nstate = 3'($urandom_range(1, 4));
        return it;
    endfunction

    initial
    begin
        reply_t z;
        reply_t r;
        int burst;
        logic [15:0] periods[4];
        logic [7:0]  limits[4];

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        slot = '0;
        ip_address = '0;
        region_number = '0;
        button = '0;
        new_state = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        purge_table();
        m_period = rtwl_pkg::PERIOD_RESET;
        m_limit = rtwl_pkg::LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        r = '0;
        r.entry_count = 5'd0;
        add_row(mk(rtwl_pkg::CMD_COUNT, 0, 0, 0, 0, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_GET_SLOT, 0, 0, 0, 0, 0), 1, z);
        r = '0;
        r.error = 1'b1;
        add_row(mk(rtwl_pkg::CMD_GET_SLOT, 8'hFF, 0, 0, 0, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_DELETE, 3, 0, 0, 0, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_ADD, 16, 1, 0, 0, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_ADD, 0, 1, 8, 0, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_ADD, 0, 1, 0, 16, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_SET_STATE, 0, 0, 0, 8'hFF, 2), 1, r);
        add_row(mk(rtwl_pkg::CMD_GET_STATE, 0, 0, 0, 8'hFF, 0), 1, r);
        add_row(mk(rtwl_pkg::CMD_ADD, 0, 32'hFFFF_FFFF, 7, 15, 7), 1, z);
        add_row(mk(rtwl_pkg::CMD_ADD, 15, 32'h0, 0, 0, 0), 1, z);
        add_row(mk(rtwl_pkg::CMD_ADD, 5, 32'hC0A8_0001, 3, 4, 0), 1, z);
        add_row(mk(rtwl_pkg::CMD_SET_STATE, 0, 0, 0, 4, 4), 1, z);
        add_row(mk(rtwl_pkg::CMD_SET_STATE, 0, 0, 0, 15, 2), 1, z);
        add_row(mk(rtwl_pkg::CMD_SET_STATE, 0, 0, 0, 4, 7), 1, z);
        add_row(mk(rtwl_pkg::CMD_GET_STATE, 0, 0, 0, 4, 0), 0, z);
        add_row(mk(rtwl_pkg::CMD_FIND_BTN, 0, 0, 0, 4, 0), 0, z);
        add_row(mk(rtwl_pkg::CMD_FIND_IP, 0, 32'hC0A8_0001, 3, 0, 0), 0, z);
        add_row(mk(rtwl_pkg::CMD_COUNT, 0, 0, 0, 0, 0), 0, z);
        add_row(mk(rtwl_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(rtwl_pkg::CMD_GET_SLOT, 15, 0, 0, 0, 0), 0, z);
        add_row(mk(rtwl_pkg::CMD_DELETE, 15, 0, 0, 0, 0), 1, z);
        add_row(mk(4'd12, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(4'd15, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 7), 1, z);
        add_row(mk(rtwl_pkg::CMD_PURGE, 0, 0, 0, 0, 0), 1, z);

        foreach (script[i])
            send_item(script[i].it, script[i].has_reply, script[i].reply);
        wait_idle();

        periods = '{16'd1, 16'd0, 16'd65535, 16'd3};
        limits = '{8'd1, 8'd165, 8'd255, 8'd8};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(rtwl_pkg::CFG_REFRESH_PERIOD, periods[ph]);
            write_reg(rtwl_pkg::CFG_REGION_LIMIT, {8'h00, limits[ph]});
            for (int n = 0; n < 225; )
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 225; b++, n++)
                    send_item(random_item(), 0, z);
                if ($urandom_range(0, 2) != 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                end
            end
            wait_idle();
        end

        if (fail_count == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
